// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sampler RTL.
// Each macro expands to a concurrent assertion clocked on clk with rst_n as disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PCS_ASSERT(lbl, prop, msg)
`define PCS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/pcs_pkg.sv =====
// Shared codes and constants of the piecewise constant sampler.
// No dependencies.
package pcs_pkg;

    localparam int DIV_W = 48;
    localparam logic [23:0] PREFIX_MAX = 24'hFFFFFF;

    localparam logic [1:0] FN_LOAD   = 2'd0;
    localparam logic [1:0] FN_BUILD  = 2'd1;
    localparam logic [1:0] FN_SAMPLE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [1:0] ST_ZERO      = 2'd2;
    localparam logic [1:0] ST_SLOT      = 2'd3;

    localparam logic [1:0] DV_FRAC = 2'd0;
    localparam logic [1:0] DV_POS  = 2'd1;
    localparam logic [1:0] DV_PDFC = 2'd2;
    localparam logic [1:0] DV_PDFD = 2'd3;

    typedef struct packed {
        logic start;
        logic [4:0] qbits;
    } div_ctrl_t;

endpackage

// ===== rtl/pcs_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating on quotient overflow.
// Depends on pcs_pkg.
module pcs_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pcs_pkg::div_ctrl_t           ctrl,
    input  logic [pcs_pkg::DIV_W-1:0]    dividend,
    input  logic [23:0]                  divisor,
    output logic                         busy,
    output logic                         done,
    output logic [23:0]                  quotient
);

    logic [24:0]               rem_reg, rem_next;
    logic [pcs_pkg::DIV_W-1:0] dsh_reg, dsh_next;
    logic [23:0]               quo_reg, quo_next;
    logic [23:0]               dvs_reg, dvs_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic [4:0]                qb_reg, qb_next;
    logic                      ovf_reg, ovf_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [pcs_pkg::DIV_W-1:0] head;
    logic [5:0]                shamt;
    logic [24:0]               cat;
    logic [25:0]               diff;

    always_comb
    begin
        head      = dividend >> ctrl.qbits;
        shamt     = 6'(pcs_pkg::DIV_W) - {1'b0, ctrl.qbits};
        cat       = {rem_reg[23:0], dsh_reg[pcs_pkg::DIV_W-1]};
        diff      = {1'b0, cat} - {2'b00, dvs_reg};
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        qb_next   = qb_reg;
        ovf_next  = ovf_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            ovf_next  = head >= pcs_pkg::DIV_W'(divisor);
            rem_next  = head[24:0];
            dsh_next  = dividend << shamt;
            dvs_next  = divisor;
            quo_next  = '0;
            cnt_next  = ctrl.qbits;
            qb_next   = ctrl.qbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dsh_next = dsh_reg << 1;
            if (!diff[25])
            begin
                rem_next = diff[24:0];
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = cat;
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        qb_reg  <= qb_next;
        ovf_reg <= ovf_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = ovf_reg ? ~(24'hFFFFFF << qb_reg) : quo_reg;

endmodule

// ===== rtl/pcs_store.sv =====
// Weight memory and prefix sum memory, one write and one registered read port each.
// Depends on nothing beyond its parameter.
module pcs_store
#(
    parameter int MAX_BUCKETS = 256
)
(
    input  logic                                 clk,
    input  logic                                 w_we,
    input  logic [$clog2(MAX_BUCKETS)-1:0]       w_waddr,
    input  logic [15:0]                          w_wdata,
    input  logic [$clog2(MAX_BUCKETS)-1:0]       w_raddr,
    output logic [15:0]                          w_rdata,
    input  logic                                 p_we,
    input  logic [$clog2(MAX_BUCKETS+1)-1:0]     p_waddr,
    input  logic [23:0]                          p_wdata,
    input  logic [$clog2(MAX_BUCKETS+1)-1:0]     p_raddr,
    output logic [23:0]                          p_rdata
);

    logic [15:0] weight_mem [MAX_BUCKETS];
    logic [23:0] prefix_mem [MAX_BUCKETS+1];

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            weight_mem[w_waddr] <= w_wdata;
        end
        w_rdata <= weight_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            prefix_mem[p_waddr] <= p_wdata;
        end
        p_rdata <= prefix_mem[p_raddr];
    end

endmodule

// ===== rtl/piecewise_constant_sampler.sv =====
// Top level of the piecewise constant sampler: stream ports, register port, sequencer.
// Depends on pcs_pkg, pcs_store, pcs_div and assert_macros.svh.
//
//  port group   role            handshake
//  s_*          command words   tvalid/tready, tuser = func
//  m_*          result words    tvalid/tready, tuser = status
//  p*           bucket_count    APB write/read, pready tied high
//
// One word at a time. A load writes one weight; a build sums the weights into the prefix memory.
// A sample searches through the prefix memory read port, then runs four divisions
// in the shared divider (16, 16, 24 and 17 quotient bits).
// A finished word waits in the output register; a new command word is taken
// once the sequencer is idle. The memories need no clearing after reset.
`include "assert_macros.svh"
module piecewise_constant_sampler
#(
    parameter int MAX_BUCKETS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // slot[7:0], weight[23:8], uniform_in[39:24]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // bucket[7:0], position[23:8], pdf_continuous[47:24],
                                   // pdf_discrete[64:48], zero fill
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_BUCKETS);
    localparam int PW = $clog2(MAX_BUCKETS + 1);
    localparam int NW = $clog2(MAX_BUCKETS + 1);
    localparam int SW = $clog2(MAX_BUCKETS + 2);
    localparam int MW = 16 + NW;

    typedef enum logic [3:0] {
        S_IDLE, S_BINIT, S_BRD, S_BACC, S_SRCH, S_CMP, S_LO, S_HI, S_DIV, S_DWAIT, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [8:0]  bucket_count_reg, bucket_count_next;
    logic        built_reg, built_next;
    logic [23:0] total_reg, total_next;
    logic [23:0] acc_reg, acc_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [SW-1:0] lo_reg, lo_next;
    logic [SW-1:0] hi_reg, hi_next;
    logic [SW-1:0] mid_reg, mid_next;
    logic [AW-1:0] b_reg, b_next;
    logic [39:0] x_reg, x_next;
    logic [23:0] lov_reg, lov_next;
    logic [23:0] hiv_reg, hiv_next;
    logic [15:0] w_reg, w_next;
    logic [15:0] t_reg, t_next;
    logic [1:0]  dsel_reg, dsel_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [15:0] res_pos_reg, res_pos_next;
    logic [23:0] res_pdfc_reg, res_pdfc_next;
    logic [16:0] res_pdfd_reg, res_pdfd_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [7:0]  out_bucket_reg, out_bucket_next;
    logic [15:0] out_pos_reg, out_pos_next;
    logic [23:0] out_pdfc_reg, out_pdfc_next;
    logic [16:0] out_pdfd_reg, out_pdfd_next;

    logic [NW-1:0] n_eff;
    logic          accept;
    logic [1:0]    func;
    logic [7:0]    slot;
    logic [15:0]   weight;
    logic [15:0]   uniform_in;
    logic          cfg_wr;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [15:0]   w_wdata, w_rdata;
    logic          p_we;
    logic [PW-1:0] p_waddr, p_raddr;
    logic [23:0]   p_wdata, p_rdata;

    pcs_pkg::div_ctrl_t          dctrl;
    logic [pcs_pkg::DIV_W-1:0]   div_dividend;
    logic [23:0]                 div_divisor;
    logic                        div_busy, div_done;
    logic [23:0]                 div_quo;

    logic [SW:0]   mid_sum;
    logic [24:0]   acc_sum;
    logic [AW-1:0] b_clamp;

    assign func       = s_tuser;
    assign slot       = s_tdata[7:0];
    assign weight     = s_tdata[23:8];
    assign uniform_in = s_tdata[39:24];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign cfg_wr     = psel && penable && pwrite && !paddr[2];
    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? 32'd0 : {23'd0, bucket_count_reg};

    always_comb
    begin
        if (bucket_count_reg == 9'd0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(bucket_count_reg) > MAX_BUCKETS)
        begin
            n_eff = NW'(MAX_BUCKETS);
        end
        else
        begin
            n_eff = NW'(bucket_count_reg);
        end
    end

    pcs_store #(.MAX_BUCKETS(MAX_BUCKETS)) u_store
    (
        .clk     (clk),
        .w_we    (w_we),
        .w_waddr (w_waddr),
        .w_wdata (w_wdata),
        .w_raddr (w_raddr),
        .w_rdata (w_rdata),
        .p_we    (p_we),
        .p_waddr (p_waddr),
        .p_wdata (p_wdata),
        .p_raddr (p_raddr),
        .p_rdata (p_rdata)
    );

    pcs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (dctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        mid_sum = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;
        acc_sum = {1'b0, acc_reg} + {9'd0, w_rdata};
        b_clamp = (lo_reg >= SW'(n_eff)) ? AW'(n_eff - NW'(1)) : AW'(lo_reg);

        w_we    = accept && (func == pcs_pkg::FN_LOAD) && (32'(slot) < 32'(n_eff));
        w_waddr = AW'(slot);
        w_wdata = weight;
        w_raddr = (state_reg == S_LO) ? b_reg : AW'(idx_reg);
        p_we    = 1'b0;
        p_waddr = PW'(idx_reg) + PW'(1);
        p_wdata = acc_sum[24] ? pcs_pkg::PREFIX_MAX : acc_sum[23:0];
        p_raddr = PW'(mid_sum);
        if (state_reg == S_BINIT)
        begin
            p_we    = 1'b1;
            p_waddr = '0;
            p_wdata = '0;
        end
        else if (state_reg == S_BACC)
        begin
            p_we = 1'b1;
        end
        if (state_reg == S_SRCH && !(hi_reg - lo_reg > SW'(1)))
        begin
            p_raddr = PW'(b_clamp);
        end
        else if (state_reg == S_LO)
        begin
            p_raddr = PW'(b_reg) + PW'(1);
        end

        dctrl.start  = (state_reg == S_DIV);
        dctrl.qbits  = 5'd16;
        div_dividend = '0;
        div_divisor  = 24'd1;
        case (dsel_reg)
            pcs_pkg::DV_FRAC:
            begin
                if (hiv_reg > lov_reg)
                begin
                    div_dividend = pcs_pkg::DIV_W'(x_reg - {lov_reg, 16'd0});
                    div_divisor  = hiv_reg - lov_reg;
                end
            end
            pcs_pkg::DV_POS:
            begin
                div_dividend = pcs_pkg::DIV_W'({b_reg, 16'd0}) + pcs_pkg::DIV_W'(t_reg);
                div_divisor  = 24'(n_eff);
            end
            pcs_pkg::DV_PDFC:
            begin
                div_dividend = pcs_pkg::DIV_W'(MW'(w_reg) * MW'(n_eff)) << 16;
                div_divisor  = total_reg;
                dctrl.qbits  = 5'd24;
            end
            default:
            begin
                div_dividend = pcs_pkg::DIV_W'(w_reg) << 16;
                div_divisor  = total_reg;
                dctrl.qbits  = 5'd17;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        bucket_count_next = bucket_count_reg;
        built_next        = built_reg;
        total_next        = total_reg;
        acc_next          = acc_reg;
        idx_next          = idx_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        b_next            = b_reg;
        x_next            = x_reg;
        lov_next          = lov_reg;
        hiv_next          = hiv_reg;
        w_next            = w_reg;
        t_next            = t_reg;
        dsel_next         = dsel_reg;
        res_status_next   = res_status_reg;
        res_pos_next      = res_pos_reg;
        res_pdfc_next     = res_pdfc_reg;
        res_pdfd_next     = res_pdfd_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_status_next   = out_status_reg;
        out_bucket_next   = out_bucket_reg;
        out_pos_next      = out_pos_reg;
        out_pdfc_next     = out_pdfc_reg;
        out_pdfd_next     = out_pdfd_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = pcs_pkg::ST_OK;
                    res_pos_next    = '0;
                    res_pdfc_next   = '0;
                    res_pdfd_next   = '0;
                    b_next          = '0;
                    state_next      = S_OUT;
                    if (func == pcs_pkg::FN_LOAD)
                    begin
                        if (w_we)
                        begin
                            built_next = 1'b0;
                        end
                        else
                        begin
                            res_status_next = pcs_pkg::ST_SLOT;
                        end
                    end
                    else if (func == pcs_pkg::FN_BUILD)
                    begin
                        state_next = S_BINIT;
                    end
                    else if (func == pcs_pkg::FN_SAMPLE)
                    begin
                        if (!built_reg)
                        begin
                            res_status_next = pcs_pkg::ST_NOT_BUILT;
                        end
                        else if (total_reg == 24'd0)
                        begin
                            res_status_next = pcs_pkg::ST_ZERO;
                        end
                        else
                        begin
                            x_next     = 40'(uniform_in) * 40'(total_reg);
                            lo_next    = '0;
                            hi_next    = SW'(n_eff) + SW'(1);
                            state_next = S_SRCH;
                        end
                    end
                end
            end
            S_BINIT:
            begin
                acc_next   = '0;
                idx_next   = '0;
                state_next = S_BRD;
            end
            S_BRD:
            begin
                state_next = S_BACC;
            end
            S_BACC:
            begin
                acc_next = p_wdata;
                idx_next = idx_reg + SW'(1);
                if (idx_reg + SW'(1) == SW'(n_eff))
                begin
                    total_next = p_wdata;
                    built_next = 1'b1;
                    if (p_wdata == 24'd0)
                    begin
                        res_status_next = pcs_pkg::ST_ZERO;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_BRD;
                end
            end
            S_SRCH:
            begin
                if (hi_reg - lo_reg > SW'(1))
                begin
                    mid_next   = mid_sum[SW-1:0];
                    state_next = S_CMP;
                end
                else
                begin
                    b_next     = b_clamp;
                    state_next = S_LO;
                end
            end
            S_CMP:
            begin
                if (p_rdata <= x_reg[39:16])
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_LO:
            begin
                lov_next   = p_rdata;
                state_next = S_HI;
            end
            S_HI:
            begin
                hiv_next   = p_rdata;
                w_next     = w_rdata;
                dsel_next  = pcs_pkg::DV_FRAC;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    case (dsel_reg)
                        pcs_pkg::DV_FRAC: t_next        = div_quo[15:0];
                        pcs_pkg::DV_POS:  res_pos_next  = div_quo[15:0];
                        pcs_pkg::DV_PDFC: res_pdfc_next = div_quo;
                        default:          res_pdfd_next = div_quo[16:0];
                    endcase
                    if (dsel_reg == pcs_pkg::DV_PDFD)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        dsel_next  = dsel_reg + 2'd1;
                        state_next = S_DIV;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_bucket_next = 8'(b_reg);
                    out_pos_next    = res_pos_reg;
                    out_pdfc_next   = res_pdfc_reg;
                    out_pdfd_next   = res_pdfd_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            bucket_count_next = pwdata[8:0];
            built_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            bucket_count_reg <= 9'd256;
            built_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            bucket_count_reg <= bucket_count_next;
            built_reg        <= built_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg      <= total_next;
        acc_reg        <= acc_next;
        idx_reg        <= idx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        b_reg          <= b_next;
        x_reg          <= x_next;
        lov_reg        <= lov_next;
        hiv_reg        <= hiv_next;
        w_reg          <= w_next;
        t_reg          <= t_next;
        dsel_reg       <= dsel_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_pdfc_reg   <= res_pdfc_next;
        res_pdfd_reg   <= res_pdfd_next;
        out_status_reg <= out_status_next;
        out_bucket_reg <= out_bucket_next;
        out_pos_reg    <= out_pos_next;
        out_pdfc_reg   <= out_pdfc_next;
        out_pdfd_reg   <= out_pdfd_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_pdfd_reg, out_pdfc_reg, out_pos_reg, out_bucket_reg};

    `PCS_ASSERT_IMP(a_search_bounds, state_reg == S_SRCH, lo_reg < hi_reg, "search bounds crossed")
    `PCS_ASSERT_IMP(a_div_idle, state_reg == S_IDLE, !div_busy, "divider busy while idle")
    `PCS_ASSERT_IMP(a_bucket_range, out_valid_reg && out_status_reg == pcs_pkg::ST_OK, 32'(out_bucket_reg) < 32'(n_eff), "bucket beyond count")

endmodule
